FILE: hdl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Types, constants and helpers shared by the chunked body decoder modules.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int SIZE_BITS = 32;
  localparam int CMP_W     = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  localparam logic [31:0] BODY_LIMIT_RST = 32'd1048576;

  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;

  // decoder phase codes
  localparam logic [2:0] PH_SIZE     = 3'd0;
  localparam logic [2:0] PH_SKIP     = 3'd1;
  localparam logic [2:0] PH_DATA     = 3'd2;
  localparam logic [2:0] PH_AFTER    = 3'd3;
  localparam logic [2:0] PH_AFTER_CR = 3'd4;
  localparam logic [2:0] PH_DONE     = 3'd5;

  // outcome codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } cbd_in_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [31:0] body_length;
  } cbd_out_t;

  typedef struct packed {
    logic [2:0]           phase;
    logic [SIZE_BITS-1:0] chunk_size;
    logic [SIZE_BITS-1:0] bytes_left;
    logic [31:0]          total_bytes;
    logic                 over_flag;
  } cbd_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } cbd_hex_t;

  // hex digit decode, either case
  function automatic cbd_hex_t hex_digit(input logic [7:0] b);
    cbd_hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: hdl/cbd_step.sv
// ----------------------------------------------------------------------------
// cbd_step
// Next-state and result logic for one payload byte of the chunked decoder.
// ----------------------------------------------------------------------------
module cbd_step (
  input  cbd_pkg::cbd_state_t cur,
  input  cbd_pkg::cbd_in_t    req,
  input  logic [31:0]         body_limit,
  output cbd_pkg::cbd_state_t nxt,
  output logic                res_valid,
  output cbd_pkg::cbd_out_t   res
);

  logic                 dvalid;
  logic                 done;
  logic                 to_size;
  logic                 line_end;
  logic [1:0]           status;
  cbd_pkg::cbd_hex_t    hex;
  logic [32:0]          room_diff;
  logic [cbd_pkg::CMP_W-1:0] room;

  always_comb begin
    nxt      = cur;
    dvalid   = 1'b0;
    done     = 1'b0;
    to_size  = 1'b0;
    line_end = 1'b0;
    status   = cbd_pkg::ST_OK;
    hex      = cbd_pkg::hex_digit(req.in_byte);
    room_diff = 33'd0;
    room      = '0;
    res_valid = 1'b0;
    res       = '0;

    case (cur.phase)
      cbd_pkg::PH_DONE: begin
        if (req.is_last) begin
          nxt = '0;
        end
      end
      cbd_pkg::PH_DATA: begin
        nxt.bytes_left = cur.bytes_left - cbd_pkg::SIZE_BITS'(1);
        if (!cur.over_flag) begin
          nxt.total_bytes = cur.total_bytes + 32'd1;
          dvalid = 1'b1;
        end
        if (nxt.bytes_left == '0) begin
          if (cur.over_flag) begin
            done   = 1'b1;
            status = cbd_pkg::ST_OVER;
          end else begin
            nxt.phase = cbd_pkg::PH_AFTER;
          end
        end
      end
      cbd_pkg::PH_AFTER_CR: begin
        nxt.phase      = (req.in_byte == cbd_pkg::CH_LF) ? cbd_pkg::PH_SIZE : cbd_pkg::PH_SKIP;
        nxt.chunk_size = '0;
        nxt.over_flag  = 1'b0;
      end
      cbd_pkg::PH_AFTER: begin
        if (req.in_byte == cbd_pkg::CH_CR) begin
          nxt.phase = cbd_pkg::PH_AFTER_CR;
        end else begin
          nxt.phase      = cbd_pkg::PH_SIZE;
          nxt.chunk_size = '0;
          nxt.over_flag  = 1'b0;
          to_size        = (req.in_byte != cbd_pkg::CH_LF);
        end
      end
      default: begin
        to_size = 1'b1;
      end
    endcase

    if (to_size) begin
      if (nxt.phase == cbd_pkg::PH_SIZE) begin
        if (hex.valid) begin
          // size would run past the counter: saturate and flag
          if (nxt.chunk_size[cbd_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
            nxt.chunk_size = '1;
            nxt.over_flag  = 1'b1;
          end else begin
            nxt.chunk_size = {nxt.chunk_size[cbd_pkg::SIZE_BITS-5:0], hex.value};
          end
        end else if (req.in_byte == cbd_pkg::CH_LF) begin
          line_end = 1'b1;
        end else begin
          nxt.phase = cbd_pkg::PH_SKIP;
        end
      end else if (req.in_byte == cbd_pkg::CH_LF) begin
        line_end = 1'b1;
      end
    end

    if (line_end) begin
      if (nxt.chunk_size == '0) begin
        done   = 1'b1;
        status = cbd_pkg::ST_OK;
      end else begin
        room_diff = {1'b0, body_limit} - {1'b0, nxt.total_bytes};
        room      = room_diff[32] ? '0 : cbd_pkg::CMP_W'(room_diff[31:0]);
        if (cbd_pkg::CMP_W'(nxt.chunk_size) > room) begin
          nxt.over_flag = 1'b1;
        end
        nxt.bytes_left = nxt.chunk_size;
        nxt.phase      = cbd_pkg::PH_DATA;
      end
    end

    if (cur.phase != cbd_pkg::PH_DONE) begin
      if (req.is_last && !done) begin
        done = 1'b1;
        if (nxt.phase == cbd_pkg::PH_DATA) begin
          status = cbd_pkg::ST_SHORT;
        end else if ((nxt.phase == cbd_pkg::PH_SIZE || nxt.phase == cbd_pkg::PH_SKIP) &&
                     nxt.chunk_size != '0) begin
          status = cbd_pkg::ST_SHORT;
        end else begin
          status = cbd_pkg::ST_OK;
        end
      end

      if (done) begin
        res.body_length = (status == cbd_pkg::ST_OK) ? nxt.total_bytes : 32'd0;
        if (req.is_last) begin
          nxt = '0;
        end else begin
          nxt.phase = cbd_pkg::PH_DONE;
        end
      end

      res_valid      = dvalid || done;
      res.data_byte  = dvalid ? req.in_byte : 8'd0;
      res.data_valid = dvalid;
      res.done_res   = done;
      res.status     = done ? status : cbd_pkg::ST_OK;
    end
  end

endmodule

FILE: hdl/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Streaming decoder for a chunked message body with a body size limit.
// ----------------------------------------------------------------------------
// One payload byte is taken per request and the decoder sustains one byte per
// clock cycle unless the output stalls. Each byte is decoded in the cycle it is
// accepted and its result (a body byte, the message outcome, or both) appears in
// the output register on the next cycle; bytes that carry neither produce no
// result. The output register is the only buffer, so in_ready follows out_ready
// whenever a result is held. The user must write body_limit through the cfg port
// only while the decoder is idle; the block does not enforce it. It resets to 1048576.
module chunked_body_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbd_pkg::cbd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbd_pkg::cbd_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  cbd_pkg::cbd_state_t state_r;
  cbd_pkg::cbd_state_t state_nxt;
  cbd_pkg::cbd_out_t   res;
  cbd_pkg::cbd_out_t   out_data_r;
  logic                res_valid;
  logic                out_valid_r;
  logic [31:0]         body_limit_r;
  logic                in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cbd_step u_step (
    .cur        (state_r),
    .req        (in_data),
    .body_limit (body_limit_r),
    .nxt        (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      out_valid_r  <= 1'b0;
      body_limit_r <= cbd_pkg::BODY_LIMIT_RST;
    end else begin
      if (cfg_valid) begin
        body_limit_r <= cfg_data;
      end
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r <= res;
    end
  end

  // a chunk in its data phase always has bytes to go
  a_data_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == cbd_pkg::PH_DATA |-> state_r.bytes_left != '0)
    else $error("data phase with no bytes left");

  // failed outcomes carry no length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res && out_data_r.status != cbd_pkg::ST_OK
      |-> out_data_r.body_length == 32'd0)
    else $error("length reported with failed outcome");

  // idle data lane stays zero
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.data_valid |-> out_data_r.data_byte == 8'd0)
    else $error("data byte set without data_valid");

  // a held result blocks new requests
  a_hold_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("request taken while result held");

endmodule

FILE: test/tb_chunked_body_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chunked_body_decoder
// Self-checking bench for the chunked body decoder. A short table of directed
// requests walks the size line, data, terminator, too-short, over-limit and
// size-overflow paths. Random messages follow under several body limits:
// mostly well-formed chunk sequences, plus truncated messages and noise. A
// byte-level decode model predicts every result, and each one is compared
// field by field. Both sides throttle at random outside one quiet phase.
// ----------------------------------------------------------------------------
module tb_chunked_body_decoder;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 206;
  localparam logic [cbd_pkg::SIZE_BITS-1:0] SIZE_ALL_ONES = '1;

  typedef enum {ROW_BYTE, ROW_CHECKED, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [31:0]       val;
    logic              last;
    cbd_pkg::cbd_out_t res;
  } stim_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  cbd_pkg::cbd_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cbd_pkg::cbd_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [31:0]       cfg_data  = '0;

  // decode model state
  logic [2:0]                    ph;
  logic [cbd_pkg::SIZE_BITS-1:0] csize;
  logic [cbd_pkg::SIZE_BITS-1:0] left;
  logic [31:0]                   total;
  logic                          over;
  logic [31:0]                   limit_reg;

  cbd_pkg::cbd_out_t expect_q[$];
  stim_row_t         dir_rows[$];
  logic [7:0]        msg_bytes[$];
  int                errors = 0;
  int                n_sent = 0;
  int                cycles = 0;
  bit                quiet  = 1'b0;
  cbd_pkg::cbd_out_t want_res;

  chunked_body_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 6);
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_line();
    ph    = cbd_pkg::PH_SIZE;
    csize = '0;
    over  = 1'b0;
  endfunction

  function automatic void clear_msg();
    clear_line();
    left  = '0;
    total = '0;
  endfunction

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - 8'h30);
    if (b >= "a" && b <= "f") return int'(b - 8'h57);
    if (b >= "A" && b <= "F") return int'(b - 8'h37);
    return -1;
  endfunction

  // advance the model by one byte; returns 1 when the byte yields a result
  function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                       output cbd_pkg::cbd_out_t r);
    logic        dv, dn, to_size, line_end;
    logic [1:0]  st;
    logic [7:0]  db;
    logic [31:0] room;
    int          d;
    dv = 1'b0; dn = 1'b0; to_size = 1'b0; line_end = 1'b0;
    st = cbd_pkg::ST_OK; db = '0; r = '0;
    case (ph)
      cbd_pkg::PH_DONE: begin
        if (last) clear_msg();
        return 1'b0;
      end
      cbd_pkg::PH_DATA: begin
        left = left - 1'b1;
        if (!over) begin
          total = total + 32'd1;
          dv = 1'b1;
          db = b;
        end
        if (left == 0) begin
          if (over) begin
            dn = 1'b1;
            st = cbd_pkg::ST_OVER;
          end else begin
            ph = cbd_pkg::PH_AFTER;
          end
        end
      end
      cbd_pkg::PH_AFTER_CR: begin
        clear_line();
        // cr without lf: the byte is swallowed by a fresh size line
        if (b != cbd_pkg::CH_LF) ph = cbd_pkg::PH_SKIP;
      end
      cbd_pkg::PH_AFTER: begin
        if (b == cbd_pkg::CH_CR) begin
          ph = cbd_pkg::PH_AFTER_CR;
        end else if (b == cbd_pkg::CH_LF) begin
          clear_line();
        end else begin
          clear_line();
          to_size = 1'b1;
        end
      end
      default: to_size = 1'b1;
    endcase

    if (to_size) begin
      d = hex_val(b);
      if (ph == cbd_pkg::PH_SIZE && d >= 0) begin
        if (csize > (SIZE_ALL_ONES >> 4)) begin
          csize = SIZE_ALL_ONES;
          over  = 1'b1;
        end else begin
          csize = {csize[cbd_pkg::SIZE_BITS-5:0], d[3:0]};
        end
      end else if (b == cbd_pkg::CH_LF) begin
        line_end = 1'b1;
      end else if (ph == cbd_pkg::PH_SIZE) begin
        ph = cbd_pkg::PH_SKIP;
      end
      if (line_end) begin
        if (csize == 0) begin
          dn = 1'b1;
          st = cbd_pkg::ST_OK;
        end else begin
          room = (total > limit_reg) ? 32'd0 : limit_reg - total;
          if (64'(csize) > 64'(room)) over = 1'b1;
          left = csize;
          ph   = cbd_pkg::PH_DATA;
        end
      end
    end

    if (last && !dn) begin
      dn = 1'b1;
      if (ph == cbd_pkg::PH_DATA ||
          ((ph == cbd_pkg::PH_SIZE || ph == cbd_pkg::PH_SKIP) && csize != 0)) begin
        st = cbd_pkg::ST_SHORT;
      end else begin
        st = cbd_pkg::ST_OK;
      end
    end

    if (dn) begin
      r.body_length = (st == cbd_pkg::ST_OK) ? total : 32'd0;
      if (last) clear_msg();
      else ph = cbd_pkg::PH_DONE;
    end
    r.data_byte  = db;
    r.data_valid = dv;
    r.done_res   = dn;
    r.status     = dn ? st : cbd_pkg::ST_OK;
    return dv || dn;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expect_q.size());
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want_res = expect_q.pop_front();
        check_field("data_byte",   32'(want_res.data_byte),  32'(out_data.data_byte));
        check_field("data_valid",  32'(want_res.data_valid), 32'(out_data.data_valid));
        check_field("done_res",    32'(want_res.done_res),   32'(out_data.done_res));
        check_field("status",      32'(want_res.status),     32'(out_data.status));
        check_field("body_length", want_res.body_length,     out_data.body_length);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  // all tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                           input cbd_pkg::cbd_out_t pin_res);
    cbd_pkg::cbd_out_t r;
    logic              has_res;
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, is_last: last};
    do @(posedge clk); while (!in_ready);
    has_res = decode_byte(b, last, r);
    if (pinned) expect_q.push_back(pin_res);
    else if (has_res) expect_q.push_back(r);
    n_sent++;
    @(negedge clk);
  endtask

  // wait for every result, then let any result-free request finish
  task automatic settle();
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic void add_row(row_kind_t k, logic [31:0] v, logic l,
                                  cbd_pkg::cbd_out_t r);
    dir_rows.push_back('{k, v, l, r});
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 10) c = 8'h30 + 8'(n);
    else c = 8'(($urandom_range(1) ? "A" : "a") + n - 10);
    return c;
  endfunction

  function automatic void push_size(int unsigned v);
    int nd;
    nd = 1;
    while ((v >> (4 * nd)) != 0 && nd < 8) nd++;
    if ($urandom_range(99) < 15) nd += $urandom_range(1, 2);
    for (int i = nd - 1; i >= 0; i--) msg_bytes.push_back(hex_char(4'(v >> (4 * i))));
  endfunction

  function automatic void push_ext();
    logic [7:0] b;
    if ($urandom_range(99) < 20) begin
      msg_bytes.push_back(";");
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(255));
        if (b == cbd_pkg::CH_LF) b = "x";
        msg_bytes.push_back(b);
      end
    end
  endfunction

  function automatic void build_message();
    int         sel, nch, sz, cut;
    logic [7:0] b;
    msg_bytes.delete();
    sel = $urandom_range(99);
    if (sel < 8) begin
      // noise, biased toward bytes the decoder reacts to
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(3))
          0: b = cbd_pkg::CH_LF;
          1: b = hex_char(4'($urandom_range(15)));
          default: b = 8'($urandom_range(255));
        endcase
        msg_bytes.push_back(b);
      end
      return;
    end
    nch = $urandom_range(0, 4);
    for (int c = 0; c < nch; c++) begin
      sel = $urandom_range(99);
      if (sel < 4) begin
        // size too wide for the counter, message cut inside its data
        msg_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 9)) msg_bytes.push_back(hex_char(4'($urandom_range(15))));
        msg_bytes.push_back(cbd_pkg::CH_LF);
        repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(255)));
        return;
      end
      sz = (sel < 12) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      push_size(sz);
      push_ext();
      msg_bytes.push_back(cbd_pkg::CH_LF);
      repeat (sz) msg_bytes.push_back(8'($urandom_range(255)));
      sel = $urandom_range(99);
      if (sel < 60) begin
        msg_bytes.push_back(cbd_pkg::CH_CR);
        msg_bytes.push_back(cbd_pkg::CH_LF);
      end else if (sel < 85) begin
        msg_bytes.push_back(cbd_pkg::CH_LF);
      end else if (sel >= 93) begin
        msg_bytes.push_back(cbd_pkg::CH_CR);
      end
    end
    push_size(0);
    push_ext();
    if ($urandom_range(99) < 30) msg_bytes.push_back(cbd_pkg::CH_CR);
    msg_bytes.push_back(cbd_pkg::CH_LF);
    if ($urandom_range(99) < 25)
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(255)));
    if ($urandom_range(99) < 12) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
  endfunction

  initial begin
    logic [31:0] limits[8];
    limit_reg = cbd_pkg::BODY_LIMIT_RST;
    clear_msg();

    // one chunk, cr without lf, zero-size line ends the message
    add_row(ROW_BYTE,    "1",   1'b0, '0);
    add_row(ROW_BYTE,    cbd_pkg::CH_LF, 1'b0, '0);
    add_row(ROW_CHECKED, 8'hff, 1'b0,
            cbd_pkg::cbd_out_t'{8'hff, 1'b1, 1'b0, cbd_pkg::ST_OK, 32'd0});
    add_row(ROW_BYTE,    cbd_pkg::CH_CR, 1'b0, '0);
    add_row(ROW_BYTE,    "q",   1'b0, '0);
    add_row(ROW_CHECKED, cbd_pkg::CH_LF, 1'b0,
            cbd_pkg::cbd_out_t'{8'h00, 1'b0, 1'b1, cbd_pkg::ST_OK, 32'd1});
    add_row(ROW_BYTE,    8'h00, 1'b1, '0);
    // input ends inside data, last data byte carries the outcome
    add_row(ROW_BYTE,    "3",   1'b0, '0);
    add_row(ROW_BYTE,    cbd_pkg::CH_LF, 1'b0, '0);
    add_row(ROW_CHECKED, 8'h00, 1'b0,
            cbd_pkg::cbd_out_t'{8'h00, 1'b1, 1'b0, cbd_pkg::ST_OK, 32'd0});
    add_row(ROW_CHECKED, 8'h80, 1'b1,
            cbd_pkg::cbd_out_t'{8'h80, 1'b1, 1'b1, cbd_pkg::ST_SHORT, 32'd0});
    // limit lowered below the running total mid-message
    add_row(ROW_BYTE,    "1",   1'b0, '0);
    add_row(ROW_BYTE,    cbd_pkg::CH_LF, 1'b0, '0);
    add_row(ROW_CHECKED, "b",   1'b0,
            cbd_pkg::cbd_out_t'{"b", 1'b1, 1'b0, cbd_pkg::ST_OK, 32'd0});
    add_row(ROW_LIMIT,   32'd0, 1'b0, '0);
    add_row(ROW_BYTE,    "1",   1'b0, '0);
    add_row(ROW_BYTE,    cbd_pkg::CH_LF, 1'b0, '0);
    add_row(ROW_CHECKED, "c",   1'b0,
            cbd_pkg::cbd_out_t'{8'h00, 1'b0, 1'b1, cbd_pkg::ST_OVER, 32'd0});
    add_row(ROW_BYTE,    8'h00, 1'b1, '0);
    // size overflow, input ends on the size line
    add_row(ROW_LIMIT,   32'hffff_ffff, 1'b0, '0);
    add_row(ROW_BYTE,    "1",   1'b0, '0);
    add_row(ROW_BYTE,    "a",   1'b0, '0);
    add_row(ROW_BYTE,    "B",   1'b0, '0);
    add_row(ROW_BYTE,    "c",   1'b0, '0);
    add_row(ROW_BYTE,    "D",   1'b0, '0);
    add_row(ROW_BYTE,    "e",   1'b0, '0);
    add_row(ROW_BYTE,    "F",   1'b0, '0);
    add_row(ROW_BYTE,    "0",   1'b0, '0);
    add_row(ROW_CHECKED, "9",   1'b1,
            cbd_pkg::cbd_out_t'{8'h00, 1'b0, 1'b1, cbd_pkg::ST_SHORT, 32'd0});

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_LIMIT:   write_limit(dir_rows[i].val);
        ROW_CHECKED: send_byte(dir_rows[i].val[7:0], dir_rows[i].last, 1'b1, dir_rows[i].res);
        default:     send_byte(dir_rows[i].val[7:0], dir_rows[i].last, 1'b0, '0);
      endcase
    end

    limits = '{32'd0, 32'd1, 32'd8, 32'd30, 32'($urandom_range(0, 300)),
               cbd_pkg::BODY_LIMIT_RST, 32'hffff_ffff, 32'd100};
    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      quiet = (p == 2);
      while (n_sent < PHASE_ITEMS * (p + 1)) begin
        // hold off now and then until the output side has drained
        if ($urandom_range(99) < 3) settle();
        build_message();
        foreach (msg_bytes[i])
          send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
      end
    end
    quiet = 1'b0;

    settle();
    repeat (4) @(posedge clk);
    if (expect_q.size() != 0) begin
      errors++;
      $display("%0t: missing results, expected %0d more, got 0", $time, expect_q.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/cbd_pkg.sv
hdl/cbd_step.sv
hdl/chunked_body_decoder.sv
test/tb_chunked_body_decoder.sv
